// ===== src/i2p_pkg.sv =====
// Shared constants, types and functions for the infix-to-postfix converter.
package i2p_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int SYM_W       = 8;

    localparam logic [SYM_W-1:0] CH_LPAREN  = 8'h28;  // '('
    localparam logic [SYM_W-1:0] CH_RPAREN  = 8'h29;  // ')'
    localparam logic [SYM_W-1:0] CH_PERCENT = 8'h25;  // '%'
    localparam logic [SYM_W-1:0] CH_HASH    = 8'h23;  // '#'
    localparam logic [SYM_W-1:0] CH_PLUS    = 8'h2B;  // '+'
    localparam logic [SYM_W-1:0] CH_MINUS   = 8'h2D;  // '-'
    localparam logic [SYM_W-1:0] CH_STAR    = 8'h2A;  // '*'
    localparam logic [SYM_W-1:0] CH_SLASH   = 8'h2F;  // '/'
    localparam logic [SYM_W-1:0] CH_CARET   = 8'h5E;  // '^'

    localparam logic [3:0] PRIO_NONE = 4'd0;

    // Stack command broadcast to every cell
    typedef struct packed {
        logic             push;
        logic             pop;
        logic [SYM_W-1:0] data;
    } i2p_stk_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_FINISH
    } i2p_state_t;

    // What ends a popping run
    typedef enum logic [1:0] {
        MODE_ALL,
        MODE_PAREN,
        MODE_OP
    } i2p_mode_t;

    // Operator priority; zero for anything that is not an operator
    function automatic logic [3:0] prio(input logic [SYM_W-1:0] c);
        logic [3:0] p;
        case (c)
            CH_PERCENT, CH_HASH: p = 4'd10;
            CH_PLUS, CH_MINUS:   p = 4'd9;
            CH_STAR, CH_SLASH:   p = 4'd7;
            CH_CARET:            p = 4'd6;
            default:             p = PRIO_NONE;
        endcase
        return p;
    endfunction

    function automatic logic is_operand(input logic [SYM_W-1:0] c);
        return (c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]});
    endfunction

endpackage

// ===== src/i2p_cell.sv =====
// One stack cell: holds one entry, shifts down on push and up on pop.
module i2p_cell
    import i2p_pkg::*;
(
    input  logic                 clk,
    input  i2p_stk_cmd_t         cmd,
    input  logic [SYM_W-1:0]     above_data,  // neighbor nearer the top (or push data)
    input  logic [SYM_W-1:0]     below_data,  // neighbor farther from the top
    output logic [SYM_W-1:0]     data
);

    logic [SYM_W-1:0] data_reg;
    logic [SYM_W-1:0] data_next;

    // Shift select
    always_comb
    begin
        data_next = data_reg;
        if (cmd.push)
        begin
            data_next = above_data;
        end
        else if (cmd.pop)
        begin
            data_next = below_data;
        end
    end

    // Payload register, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== src/i2p_stack.sv =====
// Operator stack built as a row of shifting cells; cell 0 is the top.
module i2p_stack
    import i2p_pkg::*;
(
    input  logic             clk,
    input  i2p_stk_cmd_t     cmd,
    output logic [SYM_W-1:0] top_data,
    output logic [SYM_W-1:0] second_data
);

    logic [SYM_W-1:0] cell_data [STACK_DEPTH];

    genvar i;
    generate
        for (i = 0; i < STACK_DEPTH; i++)
        begin : g_cell
            logic [SYM_W-1:0] above;
            logic [SYM_W-1:0] below;

            if (i == 0)
            begin : g_first
                assign above = cmd.data;
            end
            else
            begin : g_mid
                assign above = cell_data[i-1];
            end

            if (i == STACK_DEPTH - 1)
            begin : g_last
                assign below = cell_data[i];
            end
            else
            begin : g_inner
                assign below = cell_data[i+1];
            end

            i2p_cell u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .above_data (above),
                .below_data (below),
                .data       (cell_data[i])
            );
        end
    endgenerate

    assign top_data    = cell_data[0];
    assign second_data = cell_data[1];

endmodule

// ===== src/infix_to_postfix_converter.sv =====
// Top level: shunting-yard control, item handshakes and output register.
// An operand is written into the output register by the edge that accepts it.
// An item that needs no popping run is handled in ST_IDLE; one that pops entries
// passes ST_POP, one entry at a time while the output register is free, as the cell
// stack pops a single entry, then ST_FINISH for the push or the parenthesis discard.
// Reset (rst_n low, asynchronous): stack empty, controller idle, no item pending.
module infix_to_postfix_converter
    import i2p_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic [0:0] s_tuser,   // [0] action
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_symbol
    output logic       m_tlast    // last_in_run
);

    i2p_state_t        state_reg, state_next;
    i2p_mode_t         mode_reg, mode_next;
    logic [SYM_W-1:0]  pend_reg, pend_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]  out_sym_reg, out_sym_next;
    logic              out_last_reg, out_last_next;

    i2p_stk_cmd_t      cmd;
    logic [SYM_W-1:0]  top_data;
    logic [SYM_W-1:0]  second_data;
    logic              out_free;
    logic              accept;
    logic              full;
    logic              more;

    // Does this entry keep the popping run going
    function automatic logic keep_pop(input i2p_mode_t m, input logic [SYM_W-1:0] e,
                                      input logic [3:0] p);
        logic r;
        case (m)
            MODE_ALL:   r = 1'b1;
            MODE_PAREN: r = (e != CH_LPAREN);
            MODE_OP:    r = (e != CH_LPAREN) && (prio(e) >= p);
            default:    r = 1'b0;
        endcase
        return r;
    endfunction

    i2p_stack u_stack (
        .clk         (clk),
        .cmd         (cmd),
        .top_data    (top_data),
        .second_data (second_data)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign full     = (count_reg >= CNT_W'(STACK_DEPTH));
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign more     = (count_reg > CNT_W'(1)) && keep_pop(mode_reg, second_data, prio(pend_reg));

    // Next state, stack commands and output loading
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        pend_next      = pend_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_sym_next   = out_sym_reg;
        out_last_next  = out_last_reg;
        cmd.push       = 1'b0;
        cmd.pop        = 1'b0;
        cmd.data       = s_tdata;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pend_next = s_tdata;
                    if (s_tuser[0])
                    begin
                        mode_next = MODE_ALL;
                        if (count_reg != '0)
                        begin
                            state_next = ST_POP;
                        end
                    end
                    else if (is_operand(s_tdata))
                    begin
                        out_valid_next = 1'b1;
                        out_sym_next   = s_tdata;
                        out_last_next  = 1'b1;
                    end
                    else if (s_tdata == CH_LPAREN)
                    begin
                        if (!full)
                        begin
                            cmd.push   = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (s_tdata == CH_RPAREN)
                    begin
                        mode_next = MODE_PAREN;
                        if (count_reg != '0)
                        begin
                            if (top_data != CH_LPAREN)
                            begin
                                state_next = ST_POP;
                            end
                            else
                            begin
                                cmd.pop    = 1'b1;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                    end
                    else if (prio(s_tdata) != PRIO_NONE)
                    begin
                        mode_next = MODE_OP;
                        if ((count_reg != '0) &&
                            keep_pop(MODE_OP, top_data, prio(s_tdata)))
                        begin
                            state_next = ST_POP;
                        end
                        else if (!full)
                        begin
                            cmd.push   = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
            end

            ST_POP:
            begin
                // Emit the top, look one entry ahead to mark the last item
                if (out_free)
                begin
                    cmd.pop        = 1'b1;
                    count_next     = count_reg - CNT_W'(1);
                    out_valid_next = 1'b1;
                    out_sym_next   = top_data;
                    out_last_next  = !more;
                    if (!more)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH:
            begin
                state_next = ST_IDLE;
                case (mode_reg)
                    MODE_PAREN:
                    begin
                        if (count_reg != '0)
                        begin
                            cmd.pop    = 1'b1;
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    MODE_OP:
                    begin
                        cmd.data = pend_reg;
                        if (!full)
                        begin
                            cmd.push   = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_ALL;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        out_sym_reg  <= out_sym_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sym_reg;
    assign m_tlast  = out_last_reg;

endmodule
